>>> hdl/cwin_pkg.sv
// Shared types and constants for the cosine-sum window coefficient generator.
// Holds widths, pipeline depths, fixed-point constants and the window tables.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package cwin_pkg;

  // Field and register widths
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned LENGTH_W = 11;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned COEF_W   = 17;
  localparam int unsigned DEN_W    = 10;

  // Longest window accepted by a length write
  localparam logic [LENGTH_W-1:0] MAX_LENGTH = 11'd1024;
  localparam logic [LENGTH_W-1:0] MIN_LENGTH = 11'd2;
  localparam logic [LENGTH_W-1:0] RESET_LENGTH = 11'd1024;

  // Register indexes on the configuration port
  localparam logic [0:0] REG_WINDOW_KIND   = 1'b0;
  localparam logic [0:0] REG_WINDOW_LENGTH = 1'b1;

  // Phase division: k*n (12 bits) followed by 24 fraction bits
  localparam int unsigned PHASE_W    = 24;
  localparam int unsigned KN_W       = 12;
  localparam int unsigned DIV_W      = KN_W + PHASE_W;
  localparam int unsigned DIV_STEPS  = 6;
  localparam int unsigned DIV_STAGES = DIV_W / DIV_STEPS;

  // Pipeline depth of each unit and of the whole datapath
  localparam int unsigned TRIG_STAGES = 12;
  localparam int unsigned SUM_STAGES  = 2;
  localparam int unsigned PIPE_DEPTH  = DIV_STAGES + TRIG_STAGES + SUM_STAGES;

  typedef logic [PHASE_W-1:0] phase_t;
  typedef logic signed [31:0] cos_t;

  // Q2.30 fixed-point constants
  localparam logic [30:0] Q30_ONE       = 31'h4000_0000;
  localparam logic [31:0] PI_Q30        = 32'd3373259426;
  localparam logic [21:0] QUARTER_HALF  = 22'h20_0000;
  localparam logic [22:0] QUARTER_FULL  = 23'h40_0000;
  localparam logic [53:0] TH_ROUND      = 54'h40_0000;

  // Horner divisors as reciprocal multiply and shift, exact for 30-bit operands.
  // Row 0: cosine divisors 56, 30, 12, 2. Row 1: sine divisors 72, 42, 20, 6.
  localparam int unsigned HORNER_SHIFT [2][4] = '{
    '{36, 35, 34, 31},
    '{37, 36, 35, 33}
  };
  localparam logic [31:0] HORNER_MAGIC [2][4] = '{
    '{32'(((64'd1 << 36) + 64'd55) / 64'd56),
      32'(((64'd1 << 35) + 64'd29) / 64'd30),
      32'(((64'd1 << 34) + 64'd11) / 64'd12),
      32'(((64'd1 << 31) + 64'd1) / 64'd2)},
    '{32'(((64'd1 << 37) + 64'd71) / 64'd72),
      32'(((64'd1 << 36) + 64'd41) / 64'd42),
      32'(((64'd1 << 35) + 64'd19) / 64'd20),
      32'(((64'd1 << 33) + 64'd5) / 64'd6)}
  };

  // Window terms a0..a3 in Q2.30, one row per window kind
  localparam logic [29:0] COEF_TAB [4][4] = '{
    '{30'd536870912, 30'd536870912, 30'd0,         30'd0},
    '{30'd578059648, 30'd495682176, 30'd0,         30'd0},
    '{30'd450971566, 30'd536870912, 30'd85899346,  30'd0},
    '{30'd385204879, 30'd524297395, 30'd151698245, 30'd12541305}
  };

  // Output rounding and saturation
  localparam logic signed [63:0] ROUND_HALF = 64'sh0000_0800_0000_0000;
  localparam logic [COEF_W-1:0]  COEF_ONE   = 17'h1_0000;

endpackage

>>> hdl/cosine_sum_window_coefficient.sv
// Window coefficient generator (Hann, Hamming, Blackman, Blackman-Harris), Q1.16 out.
// Throughput: one beat per cycle while the skid entry is empty; the 20-stage datapath
// advances as a whole and a two-entry output buffer takes the overflow when the output
// side stalls.
// Reset clears all valid bits, window kind to Hann and window length to 1024.
`timescale 1ns / 1ps

module cosine_sum_window_coefficient (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [9:0] sample_index
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [16:0] coefficient
  output logic [0:0]  m_axis_tuser,   // [0] index_out_of_range
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int unsigned Depth = cwin_pkg::PIPE_DEPTH;
  localparam int unsigned CoefW = cwin_pkg::COEF_W;

  logic [cwin_pkg::KIND_W-1:0]   window_kind;
  logic [cwin_pkg::LENGTH_W-1:0] window_length;
  logic [cwin_pkg::DEN_W-1:0]    den;

  logic                          en;
  logic [cwin_pkg::INDEX_W-1:0]  n;
  logic                          oor_in;
  logic [cwin_pkg::KN_W-1:0]     kn [3];
  cwin_pkg::phase_t              phase [3];
  cwin_pkg::cos_t                cosv [3];
  logic [CoefW-1:0]              sum_coef;

  logic [Depth-1:0]              vld;
  logic [Depth-1:0]              oor_pipe;
  logic                          pipe_arrive;
  logic [CoefW-1:0]              new_coef;
  logic                          new_oor;

  logic                          out_valid;
  logic [CoefW-1:0]              out_coef;
  logic                          out_oor;
  logic                          skid_valid;
  logic [CoefW-1:0]              skid_coef;
  logic                          skid_oor;
  logic                          out_take;

  // Configuration writes; a length outside the legal range is dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_kind   <= '0;
      window_length <= cwin_pkg::RESET_LENGTH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cwin_pkg::REG_WINDOW_KIND: window_kind <= cfg_data[cwin_pkg::KIND_W-1:0];
        cwin_pkg::REG_WINDOW_LENGTH: begin
          if ((cfg_data >= cwin_pkg::MIN_LENGTH) && (cfg_data <= cwin_pkg::MAX_LENGTH)) begin
            window_length <= cfg_data;
          end
        end
        default: ;
      endcase
    end
  end

  assign den = cwin_pkg::DEN_W'(window_length - 11'd1);

  // Input side: the datapath moves whenever the output buffer has room
  assign en            = !skid_valid;
  assign s_axis_tready = en;
  assign n             = s_axis_tdata[cwin_pkg::INDEX_W-1:0];
  assign oor_in        = ({1'b0, n} >= window_length);

  assign kn[0] = cwin_pkg::KN_W'(n);
  assign kn[1] = cwin_pkg::KN_W'({n, 1'b0});
  assign kn[2] = kn[0] + kn[1];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    cwin_phase_div u_div (
      .clk   (clk),
      .en    (en),
      .kn    (kn[k]),
      .den   (den),
      .phase (phase[k])
    );

    cwin_trig u_trig (
      .clk    (clk),
      .en     (en),
      .phase  (phase[k]),
      .cosine (cosv[k])
    );
  end

  cwin_sum u_sum (
    .clk  (clk),
    .en   (en),
    .kind (window_kind),
    .cos1 (cosv[0]),
    .cos2 (cosv[1]),
    .cos3 (cosv[2]),
    .coef (sum_coef)
  );

  // Valid bits and the range flag travel beside the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oor_pipe <= {oor_pipe[Depth-2:0], oor_in};
    end
  end

  assign pipe_arrive = en && vld[Depth-1];
  assign new_oor     = oor_pipe[Depth-1];
  assign new_coef    = new_oor ? '0 : sum_coef;
  assign out_take    = out_valid && m_axis_tready;

  // Output register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) skid_valid <= 1'b0;
    end else if (pipe_arrive) begin
      if (out_valid && !m_axis_tready) skid_valid <= 1'b1;
      else out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_coef <= skid_coef;
        out_oor  <= skid_oor;
      end
    end else if (pipe_arrive) begin
      if (out_valid && !m_axis_tready) begin
        skid_coef <= new_coef;
        skid_oor  <= new_oor;
      end else begin
        out_coef <= new_coef;
        out_oor  <= new_oor;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = 24'(out_coef);
  assign m_axis_tuser  = out_oor;

  // The skid entry is only ever filled behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a beat while the output register is empty");

  // A beat reaching a stalled full output register must land in the skid entry
  a_skid_catch: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready && !skid_valid && vld[Depth-1]) |=> skid_valid)
    else $error("beat from the datapath was not caught by the skid entry");

  // The skid entry fills only after a stall on the output side
  a_skid_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !m_axis_tready))
    else $error("skid entry filled without an output stall");

  // An index beyond the window gives a zero coefficient
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[16:0] == 17'd0))
    else $error("out-of-range index produced a nonzero coefficient");

endmodule

>>> hdl/cwin_phase_div.sv
// Pipelined restoring divider giving the phase of k*x in turns, Q0.24.
// phase = floor((k*n*2^24 + floor(den/2)) / den) mod 2^24, DIV_STEPS quotient bits per stage.
// Depends on cwin_pkg.
`timescale 1ns / 1ps

module cwin_phase_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [cwin_pkg::KN_W-1:0]     kn,
  input  logic [cwin_pkg::DEN_W-1:0]    den,
  output cwin_pkg::phase_t              phase
);

  localparam int unsigned Steps  = cwin_pkg::DIV_STEPS;
  localparam int unsigned Stages = cwin_pkg::DIV_STAGES;
  localparam int unsigned DivW   = cwin_pkg::DIV_W;
  localparam int unsigned DenW   = cwin_pkg::DEN_W;

  typedef struct packed {
    logic [DivW-1:0] work;
    logic [DenW-1:0] rem;
  } div_state_t;

  // Run a group of restoring steps; quotient bits shift in at the bottom
  function automatic div_state_t div_steps(input div_state_t st, input logic [DenW-1:0] d);
    div_state_t  o;
    logic [DenW:0] r2;
    o = st;
    for (int i = 0; i < Steps; i++) begin
      r2 = {o.rem, o.work[DivW-1]};
      if (r2 >= {1'b0, d}) begin
        o.rem  = DenW'(r2 - {1'b0, d});
        o.work = {o.work[DivW-2:0], 1'b1};
      end else begin
        o.rem  = r2[DenW-1:0];
        o.work = {o.work[DivW-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  div_state_t stage_in [Stages];
  div_state_t stage_q  [Stages];
  logic [cwin_pkg::PHASE_W-1:0] rounding;

  // Numerator: k*n above 24 fraction bits, half the divisor added for rounding
  assign rounding = cwin_pkg::PHASE_W'(den >> 1);

  always_comb begin
    stage_in[0].work = {kn, rounding};
    stage_in[0].rem  = '0;
    for (int s = 1; s < Stages; s++) begin
      stage_in[s] = stage_q[s-1];
    end
  end

  // Advance every stage together
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < Stages; s++) begin
        stage_q[s] <= div_steps(stage_in[s], den);
      end
    end
  end

  // Keep the fraction of the quotient only
  assign phase = stage_q[Stages-1].work[cwin_pkg::PHASE_W-1:0];

endmodule

>>> hdl/cwin_trig.sv
// Pipelined cosine of a Q0.24 turn phase, result signed Q2.30.
// Folds to an eighth of a turn, evaluates cosine and sine Taylor series by Horner steps.
// Depends on cwin_pkg.
`timescale 1ns / 1ps

module cwin_trig (
  input  logic             clk,
  input  logic             en,
  input  cwin_pkg::phase_t phase,
  output cwin_pkg::cos_t   cosine
);

  localparam int unsigned TLen  = 5;
  localparam int unsigned ThLen = 7;
  localparam int unsigned QLen  = 10;

  // Constant reciprocal divide, then subtract from one
  function automatic logic [30:0] horner_c(input logic [61:0] q, input int unsigned sh);
    return cwin_pkg::Q30_ONE - 31'(q >> sh);
  endfunction

  logic [21:0] r;
  logic        swap;
  logic [21:0] r_fold;

  // Stage registers
  logic [53:0] th_prod;
  logic [2:0]  quad1;
  logic [29:0] th2;
  logic [29:0] th3;
  logic [29:0] t3;
  logic [29:0] tl  [TLen];
  logic [29:0] thl [ThLen];
  logic [2:0]  qd  [QLen];
  logic [61:0] bq  [4][2];
  logic [60:0] ap  [3][2];
  logic [30:0] cos11;
  logic [60:0] sp11;

  logic [30:0] sin_v;
  logic [30:0] mag;
  logic [2:0]  qs;

  // Fold the quarter turn about its middle
  assign r      = phase[21:0];
  assign swap   = (r > cwin_pkg::QUARTER_HALF);
  assign r_fold = swap ? 22'(cwin_pkg::QUARTER_FULL - {1'b0, r}) : r;

  // Angle, square, then the Horner steps for both series
  always_ff @(posedge clk) begin
    if (en) begin
      th_prod <= 54'(r_fold) * 54'(cwin_pkg::PI_Q30);
      quad1   <= {swap, phase[23:22]};
      th2     <= 30'((th_prod + cwin_pkg::TH_ROUND) >> 23);
      t3      <= 30'((60'(th2) * 60'(th2)) >> 30);
      th3     <= th2;

      tl[0]  <= t3;
      for (int i = 1; i < TLen; i++) tl[i] <= tl[i-1];
      thl[0] <= th3;
      for (int i = 1; i < ThLen; i++) thl[i] <= thl[i-1];
      qd[0]  <= quad1;
      for (int i = 1; i < QLen; i++) qd[i] <= qd[i-1];

      for (int l = 0; l < 2; l++) begin
        bq[0][l] <= 62'(t3) * 62'(cwin_pkg::HORNER_MAGIC[l][0]);
        ap[0][l] <= 61'(tl[0]) * 61'(horner_c(bq[0][l], cwin_pkg::HORNER_SHIFT[l][0]));
        bq[1][l] <= 62'(30'(ap[0][l] >> 30)) * 62'(cwin_pkg::HORNER_MAGIC[l][1]);
        ap[1][l] <= 61'(tl[2]) * 61'(horner_c(bq[1][l], cwin_pkg::HORNER_SHIFT[l][1]));
        bq[2][l] <= 62'(30'(ap[1][l] >> 30)) * 62'(cwin_pkg::HORNER_MAGIC[l][2]);
        ap[2][l] <= 61'(tl[4]) * 61'(horner_c(bq[2][l], cwin_pkg::HORNER_SHIFT[l][2]));
        bq[3][l] <= 62'(30'(ap[2][l] >> 30)) * 62'(cwin_pkg::HORNER_MAGIC[l][3]);
      end

      cos11 <= horner_c(bq[3][0], cwin_pkg::HORNER_SHIFT[0][3]);
      sp11  <= 61'(thl[ThLen-1]) * 61'(horner_c(bq[3][1], cwin_pkg::HORNER_SHIFT[1][3]));
    end
  end

  // Pick cosine or sine by quadrant and fold, negate in quadrants one and two
  assign sin_v = 31'(sp11 >> 30);
  assign qs    = qd[QLen-1];
  assign mag   = qs[0] ? (qs[2] ? cos11 : sin_v) : (qs[2] ? sin_v : cos11);

  always_ff @(posedge clk) begin
    if (en) begin
      cosine <= (qs[1] ^ qs[0]) ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

endmodule

>>> hdl/cwin_sum.sv
// Weighted cosine sum, rounding and clamping to unsigned Q1.16.
// Two register stages (products, sum); rounding is combinational from the sum.
// Depends on cwin_pkg.
`timescale 1ns / 1ps

module cwin_sum (
  input  logic                           clk,
  input  logic                           en,
  input  logic [cwin_pkg::KIND_W-1:0]    kind,
  input  cwin_pkg::cos_t                 cos1,
  input  cwin_pkg::cos_t                 cos2,
  input  cwin_pkg::cos_t                 cos3,
  output logic [cwin_pkg::COEF_W-1:0]    coef
);

  logic signed [61:0] a_ext [3];
  logic signed [61:0] c_ext [3];
  logic signed [61:0] term  [3];
  logic [29:0]        a0_q;
  logic signed [63:0] acc;
  logic signed [63:0] rnd;
  logic [19:0]        rnd_hi;

  // Sign-extend terms and cosines for the products
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a_ext[k] = 62'($signed({1'b0, cwin_pkg::COEF_TAB[kind][k+1]}));
    end
    c_ext[0] = 62'(cos1);
    c_ext[1] = 62'(cos2);
    c_ext[2] = 62'(cos3);
  end

  // Products, then alternating sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) term[k] <= a_ext[k] * c_ext[k];
      a0_q <= cwin_pkg::COEF_TAB[kind][0];
      acc  <= $signed({4'b0000, a0_q, 30'd0}) - 64'(term[0]) + 64'(term[1])
              - 64'(term[2]);
    end
  end

  // Round to Q1.16, clamp negatives to zero and saturate at one
  assign rnd    = acc + cwin_pkg::ROUND_HALF;
  assign rnd_hi = rnd[63:44];

  always_comb begin
    if (acc[63] || (acc == 64'sd0)) begin
      coef = '0;
    end else if (rnd_hi > 20'(cwin_pkg::COEF_ONE)) begin
      coef = cwin_pkg::COEF_ONE;
    end else begin
      coef = rnd_hi[cwin_pkg::COEF_W-1:0];
    end
  end

endmodule
